@@ hw/rtl/line_raster_3d_macros.svh @@
// ---------------------------------------------------------------------------
// line_raster_3d assertion macros
// Shared concurrent assertion forms for the line rasterizer checkers.
// ---------------------------------------------------------------------------
`ifndef LINE_RASTER_3D_MACROS_SVH
`define LINE_RASTER_3D_MACROS_SVH

// same-cycle implication, disabled during reset
`define LR3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_raster_3d assertion failed");

// next-cycle implication, disabled during reset
`define LR3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_raster_3d assertion failed");

`endif

@@ hw/rtl/lr3_pkg.sv @@
// ---------------------------------------------------------------------------
// lr3_pkg
// Types and constants shared by the 3D line rasterizer modules.
// ---------------------------------------------------------------------------
package lr3_pkg;

  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int SIZE_W    = 7;
  localparam int IDX_W     = 18;
  localparam int ERR_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = SIZE_W;
  localparam int DIM_MAX_DEF = 64;
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] end_z;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] vox_x;
    logic [COORD_W-1:0] vox_y;
    logic [COORD_W-1:0] vox_z;
    logic [IDX_W-1:0]   voxel_index;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               inside_res;
    logic               last_point;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_end;
    logic s1_valid;
  } ctrl_sts_t;

endpackage

@@ hw/rtl/lr3_ctrl.sv @@
// ---------------------------------------------------------------------------
// lr3_ctrl
// Sequencer for one line command: load, setup, walk, drain.
// ---------------------------------------------------------------------------
module lr3_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lr3_pkg::ctrl_sts_t sts,
  output logic               busy,
  output lr3_pkg::ctrl_cmd_t cmd
);

  lr3_pkg::state_t state_r;
  lr3_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lr3_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      lr3_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = lr3_pkg::ST_SETUP;
        end
      end
      lr3_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = lr3_pkg::ST_WALK;
      end
      lr3_pkg::ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.at_end) begin
          state_nxt = lr3_pkg::ST_DRAIN;
        end
      end
      lr3_pkg::ST_DRAIN: begin
        if (!sts.s1_valid) begin
          state_nxt = lr3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lr3_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/lr3_datapath.sv @@
// ---------------------------------------------------------------------------
// lr3_datapath
// Size registers, Bresenham walker and two-stage voxel index pipeline.
// ---------------------------------------------------------------------------
module lr3_datapath #(
  parameter int DIM_MAX = lr3_pkg::DIM_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lr3_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [lr3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lr3_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  lr3_pkg::ctrl_cmd_t                  cmd,
  output lr3_pkg::ctrl_sts_t                  sts,
  output logic                                out_valid,
  output lr3_pkg::out_item_t                  out_item
);

  localparam int CW = lr3_pkg::COORD_W;
  localparam int SW = lr3_pkg::SIZE_W;
  localparam int EW = lr3_pkg::ERR_W;
  localparam int IW = lr3_pkg::IDX_W;
  localparam int YW = CW + SW;
  localparam int PW = 2 * SW;

  logic [SW-1:0] size_x_r, size_y_r, size_z_r;
  logic [SW-1:0] sx_c, sy_c, sz_c;

  logic [CW-1:0] pos_r [3];
  logic [CW-1:0] end_r [3];
  logic [CW-1:0] d_r   [3];
  logic          s_r   [3];
  logic [EW-1:0] err_r [3];
  logic [1:0]    axis_r;
  logic [3*lr3_pkg::COLOR_W-1:0] colour_r;
  logic [PW-1:0] sxy_r;

  logic [CW-1:0] d_c   [3];
  logic [1:0]    axis_c;
  logic [CW-1:0] pos_nxt [3];
  logic [EW-1:0] err_nxt [3];
  logic          at_end;

  logic          s1_valid_r;
  logic [CW-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [YW-1:0] s1_ysx_r;
  logic [IW-1:0] s1_zsxy_r;
  logic          s1_in_r;
  logic          s1_last_r;
  logic [IW-1:0] zsxy_c;

  logic               out_valid_r;
  lr3_pkg::out_item_t out_item_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= lr3_pkg::SIZE_RST;
      size_y_r <= lr3_pkg::SIZE_RST;
      size_z_r <= lr3_pkg::SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lr3_pkg::CFG_SIZE_X: size_x_r <= cfg_data;
        lr3_pkg::CFG_SIZE_Y: size_y_r <= cfg_data;
        lr3_pkg::CFG_SIZE_Z: size_z_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sx_c = (32'(size_x_r) > 32'(DIM_MAX)) ? SW'(DIM_MAX) : size_x_r;
    sy_c = (32'(size_y_r) > 32'(DIM_MAX)) ? SW'(DIM_MAX) : size_y_r;
    sz_c = (32'(size_z_r) > 32'(DIM_MAX)) ? SW'(DIM_MAX) : size_z_r;
  end

  // deltas and driving axis from the loaded endpoints
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = (end_r[i] >= pos_r[i]) ? end_r[i] - pos_r[i] : pos_r[i] - end_r[i];
    end
    if (d_c[0] >= d_c[1] && d_c[0] >= d_c[2]) begin
      axis_c = lr3_pkg::AXIS_X;
    end else if (d_c[1] >= d_c[2]) begin
      axis_c = lr3_pkg::AXIS_Y;
    end else begin
      axis_c = lr3_pkg::AXIS_Z;
    end
  end

  // one Bresenham step
  always_comb begin
    at_end = (pos_r[axis_r] == end_r[axis_r]);
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = pos_r[i];
      err_nxt[i] = err_r[i] + EW'({d_r[i], 1'b0});
      if (2'(i) == axis_r) begin
        pos_nxt[i] = s_r[i] ? pos_r[i] + CW'(1) : pos_r[i] - CW'(1);
        err_nxt[i] = err_r[i];
      end else if (!err_r[i][EW-1]) begin
        pos_nxt[i] = s_r[i] ? pos_r[i] + CW'(1) : pos_r[i] - CW'(1);
        err_nxt[i] = err_r[i] - EW'({d_r[axis_r], 1'b0}) + EW'({d_r[i], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r[0] <= in_item.start_x;
      pos_r[1] <= in_item.start_y;
      pos_r[2] <= in_item.start_z;
      end_r[0] <= in_item.end_x;
      end_r[1] <= in_item.end_y;
      end_r[2] <= in_item.end_z;
      colour_r <= {in_item.red, in_item.green, in_item.blue};
    end else if (cmd.setup) begin
      axis_r <= axis_c;
      sxy_r  <= PW'(sx_c) * PW'(sy_c);
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= d_c[i];
        s_r[i]   <= (end_r[i] > pos_r[i]);
        err_r[i] <= EW'({d_c[i], 1'b0}) - EW'(d_c[axis_c]);
      end
    end else if (cmd.step && !at_end) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= pos_nxt[i];
        err_r[i] <= err_nxt[i];
      end
    end
  end

  // stage 1: clip and partial products
  assign zsxy_c = IW'(pos_r[2]) * IW'(sxy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      s1_x_r    <= pos_r[0];
      s1_y_r    <= pos_r[1];
      s1_z_r    <= pos_r[2];
      s1_ysx_r  <= YW'(pos_r[1]) * YW'(sx_c);
      s1_zsxy_r <= zsxy_c;
      s1_in_r   <= (SW'(pos_r[0]) < sx_c) && (SW'(pos_r[1]) < sy_c) &&
                   (SW'(pos_r[2]) < sz_c);
      s1_last_r <= at_end;
    end
  end

  // stage 2: index sum and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_item_r.vox_x       <= s1_x_r;
      out_item_r.vox_y       <= s1_y_r;
      out_item_r.vox_z       <= s1_z_r;
      out_item_r.voxel_index <= s1_in_r ?
                                (s1_zsxy_r + IW'(s1_ysx_r) + IW'(s1_x_r)) : '0;
      out_item_r.red_out     <= colour_r[3*lr3_pkg::COLOR_W-1:2*lr3_pkg::COLOR_W];
      out_item_r.green_out   <= colour_r[2*lr3_pkg::COLOR_W-1:lr3_pkg::COLOR_W];
      out_item_r.blue_out    <= colour_r[lr3_pkg::COLOR_W-1:0];
      out_item_r.inside_res  <= s1_in_r;
      out_item_r.last_point  <= s1_last_r;
    end
  end

  assign sts.at_end   = at_end;
  assign sts.s1_valid = s1_valid_r;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

@@ hw/rtl/line_raster_3d.sv @@
// ---------------------------------------------------------------------------
// line_raster_3d
// 3D Bresenham line rasterizer: one result per voxel, start to end inclusive.
// ---------------------------------------------------------------------------
//  channel  ports                            transfer
//  in       start, busy, in_item             start && !busy at clk edge
//  out      out_valid, out_item              one-cycle strobe, no stall
//  cfg      cfg_we, cfg_index, cfg_data      cfg_we at clk edge
//
//  A line of N voxels (N = largest axis delta + 1, at most 64) keeps busy
//  high through the setup state, the walk of the stepper over all N voxels
//  and the drain of the index pipeline (clip/multiply, then sum).
//  Results of one line appear on consecutive cycles.
//  Reset is synchronous, active low; sizes reset to 64.
//  The receiver cannot stall; out_valid marks each result for one cycle.
// ---------------------------------------------------------------------------
module line_raster_3d #(
  parameter int DIM_MAX = lr3_pkg::DIM_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lr3_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output lr3_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lr3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lr3_pkg::CFG_DAT_W-1:0] cfg_data
);

  lr3_pkg::ctrl_cmd_t cmd;
  lr3_pkg::ctrl_sts_t sts;

  lr3_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  lr3_datapath #(
    .DIM_MAX (DIM_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ hw/rtl/lr3_checker.sv @@
// ---------------------------------------------------------------------------
// lr3_checker
// Port-level assertions for the 3D line rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_raster_3d_macros.svh"

module lr3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input lr3_pkg::out_item_t out_item
);

  `LR3_ASSERT_IMP(a_out_in_busy, clk, rst_n, out_valid, busy)
  `LR3_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `LR3_ASSERT_NXT(a_line_contig, clk, rst_n, out_valid && !out_item.last_point, out_valid)
  `LR3_ASSERT_IMP(a_clip_index, clk, rst_n, out_valid && !out_item.inside_res, out_item.voxel_index == '0)

endmodule

bind line_raster_3d lr3_checker u_lr3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
